// ===== hdl/yaw_pitch_from_two_points_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the yaw and pitch core
// Clocked assertions with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef YAW_PITCH_FROM_TWO_POINTS_CORE_ASSERT_SVH
`define YAW_PITCH_FROM_TWO_POINTS_CORE_ASSERT_SVH

`define YPFP_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

`define YPFP_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== hdl/ypfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ypfp_pkg
// Types, constants and the arctangent table for the yaw and pitch core.
// ----------------------------------------------------------------------------
package ypfp_pkg;

  localparam int W             = 64;
  localparam int AW            = 36;
  localparam int SCALE         = 24;
  localparam int DEFAULT_STEPS = 20;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QCW           = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [AW-1:0] DEG90  = AW'(64'd90 << SCALE);
  localparam logic signed [AW-1:0] DEG180 = AW'(64'd180 << SCALE);
  localparam logic signed [AW-1:0] DEG270 = AW'(64'd270 << SCALE);
  localparam logic signed [AW-1:0] DEG360 = AW'(64'd360 << SCALE);
  localparam logic signed [AW-1:0] YAW_MAX   = AW'(64'd23592960);
  localparam logic signed [AW-1:0] PITCH_LIM = AW'(64'd5898240);

  typedef struct packed {
    logic signed [W-1:0]  yx;
    logic signed [W-1:0]  yy;
    logic signed [W-1:0]  zx;
    logic signed [AW-1:0] yz0;
    logic                 yaw_fix;
    logic signed [AW-1:0] yaw_val;
    logic                 pitch_fix;
    logic signed [AW-1:0] pitch_val;
    logic                 dz_pos;
    logic                 degen;
  } work_t;

  typedef struct packed {
    logic signed [W-1:0]  ax;
    logic signed [W-1:0]  ay;
    logic signed [W-1:0]  bx;
    logic signed [W-1:0]  by;
    logic signed [AW-1:0] yz;
    logic signed [AW-1:0] pz;
    logic                 yaw_fix;
    logic signed [AW-1:0] yaw_val;
    logic                 pitch_fix;
    logic signed [AW-1:0] pitch_val;
    logic                 dz_pos;
    logic                 degen;
  } stage_t;

  function automatic logic signed [AW-1:0] atan_q24(input int idx);
    longint unsigned acc;
    longint unsigned term;
    longint unsigned r32;
    longint unsigned p;
    int k;
    acc = 64'd0;
    if (idx == 0) begin
      return AW'(64'd45 << SCALE);
    end
    for (k = 1; idx * k < 62; k += 2) begin
      term = (64'd1 << 62) >> (idx * k);
      term = term / 64'(k);
      if (((k >> 1) & 1) != 0) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    r32 = (acc + (64'd1 << 29)) >> 30;
    p = (r32 * 64'd961263669 + (64'd1 << 31)) >> 32;
    return AW'(p);
  endfunction

endpackage

// ===== hdl/ypfp_front.sv =====
// ----------------------------------------------------------------------------
// ypfp_front
// Accepts point pairs, forms the difference and classifies the axis cases.
// ----------------------------------------------------------------------------
module ypfp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       src_x,
  input  logic signed [31:0]       src_y,
  input  logic signed [31:0]       src_z,
  input  logic signed [31:0]       dst_x,
  input  logic signed [31:0]       dst_y,
  input  logic signed [31:0]       dst_z,
  input  logic [ypfp_pkg::QCW-1:0] q_count,
  output logic                     push,
  output ypfp_pkg::work_t          push_data
);
  import ypfp_pkg::*;

  logic                 f_valid;
  work_t                f_next;
  logic signed [32:0]   dx, dy, dz, adz;
  logic signed [W-1:0]  sx, sy, bx, by;
  logic                 hz;
  logic [QCW:0]         occ;

  assign occ      = {1'b0, q_count} + (QCW+1)'(f_valid);
  assign in_stall = occ >= (QCW+1)'(QUEUE_DEPTH);
  assign push     = f_valid;

  always_comb begin
    dx  = {src_x[31], src_x} - {dst_x[31], dst_x};
    dy  = {src_y[31], src_y} - {dst_y[31], dst_y};
    dz  = {src_z[31], src_z} - {dst_z[31], dst_z};
    adz = (dz < 0) ? -dz : dz;
    sx  = W'(dx) <<< SCALE;
    sy  = -(W'(dy) <<< SCALE);
    hz  = (dx == 0) && (dy == 0);
    bx  = sy;
    by  = sx;
    f_next.yz0 = '0;
    if (sy < 0) begin
      if (sx >= 0) begin
        bx = sx;
        by = -sy;
        f_next.yz0 = DEG90;
      end else begin
        bx = -sx;
        by = sy;
        f_next.yz0 = -DEG90;
      end
    end
    f_next.yx      = bx;
    f_next.yy      = by;
    f_next.zx      = W'(adz) <<< SCALE;
    f_next.yaw_fix = (dx == 0) || (dy == 0);
    if (hz) begin
      f_next.yaw_val = DEG180;
    end else if (dx == 0) begin
      f_next.yaw_val = (dy < 0) ? DEG180 : DEG360;
    end else begin
      f_next.yaw_val = (dx > 0) ? DEG270 : DEG90;
    end
    f_next.pitch_fix = hz || (dz == 0);
    if (dz == 0) begin
      f_next.pitch_val = '0;
    end else begin
      f_next.pitch_val = (dz > 0) ? -DEG90 : DEG90;
    end
    f_next.dz_pos = dz > 0;
    f_next.degen  = hz && (dz == 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      push_data <= f_next;
    end
  end

endmodule

// ===== hdl/ypfp_queue.sv =====
// ----------------------------------------------------------------------------
// ypfp_queue
// Short queue of classified items between the front and the CORDIC pipeline.
// ----------------------------------------------------------------------------
module ypfp_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  ypfp_pkg::work_t          push_data,
  input  logic                     pop,
  output logic                     q_valid,
  output ypfp_pkg::work_t          head,
  output logic [ypfp_pkg::QCW-1:0] q_count
);
  import ypfp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  work_t            mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [QCW-1:0]   count;
  logic             do_pop;

  assign q_valid = count != '0;
  assign q_count = count;
  assign head    = mem[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + QCW'(push) - QCW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/ypfp_back.sv =====
// ----------------------------------------------------------------------------
// ypfp_back
// Unrolled vectoring CORDIC: yaw and height runs, then the pitch run.
// ----------------------------------------------------------------------------
module ypfp_back #(
  parameter int STEPS = ypfp_pkg::DEFAULT_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ypfp_pkg::work_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        yaw_deg,
  output logic signed [23:0] pitch_deg,
  output logic               degenerate
);
  import ypfp_pkg::*;

  localparam int L = 2 * STEPS;

  logic   en;
  logic   v  [L];
  stage_t st [L];
  stage_t head_st;
  stage_t last;
  logic signed [AW-1:0] yaw24, pitch24, yaw_r, pitch_r;

  assign en  = !out_valid || !out_stall;
  assign pop = en && q_valid;

  always_comb begin
    head_st.ax        = head.yx;
    head_st.ay        = head.yy;
    head_st.bx        = head.zx;
    head_st.by        = '0;
    head_st.yz        = head.yz0;
    head_st.pz        = '0;
    head_st.yaw_fix   = head.yaw_fix;
    head_st.yaw_val   = head.yaw_val;
    head_st.pitch_fix = head.pitch_fix;
    head_st.pitch_val = head.pitch_val;
    head_st.dz_pos    = head.dz_pos;
    head_st.degen     = head.degen;
  end

  for (genvar s = 0; s < L; s++) begin : g_stage
    localparam int I = (s < STEPS) ? s : s - STEPS;
    localparam logic signed [AW-1:0] ANG = atan_q24(I);
    stage_t c, p, n;
    logic   cv;
    logic signed [W-1:0] axs, ays, bxs, bys;

    if (s == 0) begin : g_first
      assign c  = head_st;
      assign cv = q_valid;
    end else begin : g_next
      assign c  = st[s-1];
      assign cv = v[s-1];
    end

    always_comb begin
      p = c;
      if (s == STEPS) begin
        p.ay = c.bx;
        p.pz = '0;
      end
      axs = $signed(p.ax) >>> I;
      ays = $signed(p.ay) >>> I;
      bxs = $signed(p.bx) >>> I;
      bys = $signed(p.by) >>> I;
      n = p;
      if ($signed(p.ay) > 0) begin
        n.ax = p.ax + ays;
        n.ay = p.ay - axs;
        if (s < STEPS) begin
          n.yz = p.yz + ANG;
        end else begin
          n.pz = p.pz + ANG;
        end
      end else begin
        n.ax = p.ax - ays;
        n.ay = p.ay + axs;
        if (s < STEPS) begin
          n.yz = p.yz - ANG;
        end else begin
          n.pz = p.pz - ANG;
        end
      end
      if (s < STEPS) begin
        if ($signed(p.by) > 0) begin
          n.bx = p.bx + bys;
          n.by = p.by - bxs;
        end else begin
          n.bx = p.bx - bys;
          n.by = p.by + bxs;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s] <= n;
      end
    end
  end

  always_comb begin
    last    = st[L-1];
    yaw24   = last.yaw_fix ? last.yaw_val : last.yz + DEG180;
    pitch24 = last.pitch_fix ? last.pitch_val : (last.dz_pos ? -last.pz : last.pz);
    yaw_r   = (yaw24 + AW'(128)) >>> 8;
    pitch_r = (pitch24 + AW'(128)) >>> 8;
    if (yaw_r < 0) begin
      yaw_r = '0;
    end else if (yaw_r > YAW_MAX) begin
      yaw_r = YAW_MAX;
    end
    if (pitch_r < -PITCH_LIM) begin
      pitch_r = -PITCH_LIM;
    end else if (pitch_r > PITCH_LIM) begin
      pitch_r = PITCH_LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_deg    <= yaw_r[24:0];
      pitch_deg  <= pitch_r[23:0];
      degenerate <= last.degen;
    end
  end

endmodule

// ===== hdl/yaw_pitch_from_two_points_core.sv =====
// Yaw and pitch from two points. One pair of points enters per cycle while
// in_stall is low and one result leaves per cycle while out_stall is low; a
// result passes through the input register, the queue, the CORDIC stages and
// the output register. The depth comes from the pitch angle, which needs the
// horizontal length from the yaw CORDIC run before its own run of CORDIC_STEPS
// stages can start. A four-item queue after the input register lets the input
// keep flowing while the output is stalled, until the queue fills.
// ----------------------------------------------------------------------------
// yaw_pitch_from_two_points_core
// Top level: front classifier, queue and CORDIC pipeline.
// ----------------------------------------------------------------------------
module yaw_pitch_from_two_points_core #(
  parameter int CORDIC_STEPS = ypfp_pkg::DEFAULT_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] src_x,
  input  logic signed [31:0] src_y,
  input  logic signed [31:0] src_z,
  input  logic signed [31:0] dst_x,
  input  logic signed [31:0] dst_y,
  input  logic signed [31:0] dst_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        yaw_deg,
  output logic signed [23:0] pitch_deg,
  output logic               degenerate
);
  import ypfp_pkg::*;

  logic           push, pop, q_valid;
  work_t          push_data, head;
  logic [QCW-1:0] q_count;

  ypfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .src_x     (src_x),
    .src_y     (src_y),
    .src_z     (src_z),
    .dst_x     (dst_x),
    .dst_y     (dst_y),
    .dst_z     (dst_z),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  ypfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head),
    .q_count   (q_count)
  );

  ypfp_back #(
    .STEPS (CORDIC_STEPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .yaw_deg    (yaw_deg),
    .pitch_deg  (pitch_deg),
    .degenerate (degenerate)
  );

endmodule

// ===== hdl/ypfp_checker.sv =====
// ----------------------------------------------------------------------------
// ypfp_checker
// Port-level checks on the yaw and pitch core, bound to the top level.
// ----------------------------------------------------------------------------
`include "yaw_pitch_from_two_points_core_assert.svh"

module ypfp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] src_x,
  input logic signed [31:0] src_y,
  input logic signed [31:0] src_z,
  input logic signed [31:0] dst_x,
  input logic signed [31:0] dst_y,
  input logic signed [31:0] dst_z,
  input logic               out_valid,
  input logic               out_stall,
  input logic [24:0]        yaw_deg,
  input logic signed [23:0] pitch_deg,
  input logic               degenerate
);

  `YPFP_ASSERT_ALWAYS(a_rst_clears, clk, rst |=> !out_valid, "output valid after reset")
  `YPFP_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(yaw_deg) && $stable(pitch_deg) && $stable(degenerate), "stalled result changed")
  `YPFP_ASSERT(a_degen, clk, rst, out_valid && degenerate |-> yaw_deg == 25'd11796480 && pitch_deg == 24'sd0, "degenerate result not 180 and 0")
  `YPFP_ASSERT(a_range, clk, rst, out_valid |-> yaw_deg <= 25'd23592960 && pitch_deg <= 24'sd5898240 && pitch_deg >= -24'sd5898240, "angle out of range")

endmodule

bind yaw_pitch_from_two_points_core ypfp_checker u_ypfp_checker (.*);
